[design/sec_pkg.sv]
// ----------------------------------------------------------------------------
// sec_pkg
// Shared constants and result codes for the splint edge classifier.
// ----------------------------------------------------------------------------
package sec_pkg;

  // Default field widths of positions and identifiers.
  localparam int READ_POS_BITS_DEF = 16;
  localparam int CTG_POS_BITS_DEF  = 24;
  localparam int CID_BITS_DEF      = 32;

  // Fixed field widths.
  localparam int SCORE_BITS     = 16;
  localparam int GAP_BITS       = 26;
  localparam int OVL_BITS       = 16;
  localparam int GAP_POS_BITS   = 25;
  localparam int STATUS_BITS    = 3;

  // Classification of one pair of alignments.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_EDGE     = 3'd0,
    ST_CONTAIN  = 3'd1,
    ST_CIRCULAR = 3'd2,
    ST_SHORT    = 3'd3,
    ST_BADOVL   = 3'd4,
    ST_GAPERR   = 3'd5
  } sec_status_t;

  // Contig end codes.
  localparam logic END_3P = 1'b0;
  localparam logic END_5P = 1'b1;

endpackage

[design/splint_edge_classifier.sv]
// Path: a record passes the input register, then the result register, where its result
// waits for its transfer; back-pressure on the output holds it there.
// Throughput: one record per cycle while the result register is not stalled, set by the single
// classification pass between the two registers; a first-of-pair record yields no result. Reset clears both
// valid flags and the held record to zero.
// ----------------------------------------------------------------------------
// splint_edge_classifier
// Pairs alignment records of one read and emits a contig edge or a rejection
// status for every second record of a pair.
// ----------------------------------------------------------------------------
module splint_edge_classifier
  import sec_pkg::*;
#(
  parameter int READ_POS_BITS = READ_POS_BITS_DEF,
  parameter int CTG_POS_BITS  = CTG_POS_BITS_DEF,
  parameter int CID_BITS      = CID_BITS_DEF,
  localparam int IN_RAW  = 3 * READ_POS_BITS + 3 * CTG_POS_BITS + CID_BITS + 1 + SCORE_BITS,
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = 2 * CID_BITS + 2 + GAP_BITS + OVL_BITS + SCORE_BITS
                           + GAP_POS_BITS + 2,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // read_start, read_stop, read_length, contig_start, contig_stop, contig_length,
  // contig_id, reverse_strand, align_score, zero fill
  input  logic [IN_W-1:0]        s_tdata,
  // second_of_pair
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // cid_high, cid_low, end_high, end_low, gap, overlap_len, edge_score,
  // gap position, gap_read_reverse, gap_read_present, zero fill
  output logic [OUT_W-1:0]       m_tdata,
  // status
  output logic [STATUS_BITS-1:0] m_tuser
);

  localparam int RB = READ_POS_BITS;
  localparam int CB = CTG_POS_BITS;

  // Input register.
  logic                 in_valid;
  logic                 in_second;
  logic [RB-1:0]        in_read_start, in_read_stop, in_read_length;
  logic [CB-1:0]        in_contig_start, in_contig_stop, in_contig_length;
  logic [CID_BITS-1:0]  in_contig_id;
  logic                 in_reverse;
  logic [SCORE_BITS-1:0] in_score;
  logic                 in_fire, hold_load, out_load;

  // Held record.
  logic [RB-1:0]        held_read_start, held_read_stop, held_read_length;
  logic [CB-1:0]        held_contig_start, held_contig_stop, held_contig_length;
  logic [CID_BITS-1:0]  held_contig_id;
  logic                 held_reverse;
  logic [SCORE_BITS-1:0] held_score;

  // Classification result.
  sec_status_t               c_status;
  logic [CID_BITS-1:0]       c_cid_high, c_cid_low;
  logic                      c_end_high, c_end_low;
  logic [GAP_BITS-1:0]       c_gap;
  logic [OVL_BITS-1:0]       c_overlap_len;
  logic [SCORE_BITS-1:0]     c_edge_score;
  logic [GAP_POS_BITS-1:0]   c_gap_pos;
  logic                      c_gap_read_reverse, c_gap_read_present;

  // A stored record leaves the input register at once; an evaluated one
  // needs room in the result register.
  assign in_fire   = in_valid && (!in_second || !m_tvalid || m_tready);
  assign s_tready  = !in_valid || in_fire;
  assign hold_load = in_fire && !in_second;
  assign out_load  = in_fire && in_second;

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Input register payload, unpacked from the transfer.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_second        <= s_tuser;
      in_read_start    <= s_tdata[0 +: RB];
      in_read_stop     <= s_tdata[RB +: RB];
      in_read_length   <= s_tdata[2*RB +: RB];
      in_contig_start  <= s_tdata[3*RB +: CB];
      in_contig_stop   <= s_tdata[3*RB+CB +: CB];
      in_contig_length <= s_tdata[3*RB+2*CB +: CB];
      in_contig_id     <= s_tdata[3*RB+3*CB +: CID_BITS];
      in_reverse       <= s_tdata[3*RB+3*CB+CID_BITS];
      in_score         <= s_tdata[3*RB+3*CB+CID_BITS+1 +: SCORE_BITS];
    end
  end

  sec_hold #(
    .READ_POS_BITS(READ_POS_BITS),
    .CTG_POS_BITS (CTG_POS_BITS),
    .CID_BITS     (CID_BITS)
  ) u_hold (
    .clk               (clk),
    .rst               (rst),
    .load              (hold_load),
    .read_start        (in_read_start),
    .read_stop         (in_read_stop),
    .read_length       (in_read_length),
    .contig_start      (in_contig_start),
    .contig_stop       (in_contig_stop),
    .contig_length     (in_contig_length),
    .contig_id         (in_contig_id),
    .reverse_strand    (in_reverse),
    .align_score       (in_score),
    .held_read_start   (held_read_start),
    .held_read_stop    (held_read_stop),
    .held_read_length  (held_read_length),
    .held_contig_start (held_contig_start),
    .held_contig_stop  (held_contig_stop),
    .held_contig_length(held_contig_length),
    .held_contig_id    (held_contig_id),
    .held_reverse      (held_reverse),
    .held_score        (held_score)
  );

  sec_classify #(
    .READ_POS_BITS(READ_POS_BITS),
    .CTG_POS_BITS (CTG_POS_BITS),
    .CID_BITS     (CID_BITS)
  ) u_classify (
    .a_read_start    (in_read_start),
    .a_read_stop     (in_read_stop),
    .a_read_length   (in_read_length),
    .a_contig_start  (in_contig_start),
    .a_contig_stop   (in_contig_stop),
    .a_contig_length (in_contig_length),
    .a_contig_id     (in_contig_id),
    .a_reverse       (in_reverse),
    .a_score         (in_score),
    .b_read_start    (held_read_start),
    .b_read_stop     (held_read_stop),
    .b_contig_start  (held_contig_start),
    .b_contig_stop   (held_contig_stop),
    .b_contig_length (held_contig_length),
    .b_contig_id     (held_contig_id),
    .b_reverse       (held_reverse),
    .b_score         (held_score),
    .status          (c_status),
    .cid_high        (c_cid_high),
    .cid_low         (c_cid_low),
    .end_high        (c_end_high),
    .end_low         (c_end_low),
    .gap             (c_gap),
    .overlap_len     (c_overlap_len),
    .edge_score      (c_edge_score),
    .gap_pos         (c_gap_pos),
    .gap_read_reverse(c_gap_read_reverse),
    .gap_read_present(c_gap_read_present)
  );

  // The held length is not part of the classification.
  logic unused_held_len;
  assign unused_held_len = ^held_read_length;

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register payload, packed from the lowest bit up.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= c_status;
      m_tdata <= OUT_W'({c_gap_read_present, c_gap_read_reverse, c_gap_pos,
                         c_edge_score, c_overlap_len, c_gap, c_end_low, c_end_high,
                         c_cid_low, c_cid_high}) & {OUT_W{~unused_held_len | 1'b1}};
    end
  end

endmodule

[design/sec_hold.sv]
// ----------------------------------------------------------------------------
// sec_hold
// Register that keeps the first alignment of a pair until it is replaced.
// ----------------------------------------------------------------------------
module sec_hold
  import sec_pkg::*;
#(
  parameter int READ_POS_BITS = READ_POS_BITS_DEF,
  parameter int CTG_POS_BITS  = CTG_POS_BITS_DEF,
  parameter int CID_BITS      = CID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [READ_POS_BITS-1:0] read_start,
  input  logic [READ_POS_BITS-1:0] read_stop,
  input  logic [READ_POS_BITS-1:0] read_length,
  input  logic [CTG_POS_BITS-1:0]  contig_start,
  input  logic [CTG_POS_BITS-1:0]  contig_stop,
  input  logic [CTG_POS_BITS-1:0]  contig_length,
  input  logic [CID_BITS-1:0]      contig_id,
  input  logic                     reverse_strand,
  input  logic [SCORE_BITS-1:0]    align_score,
  output logic [READ_POS_BITS-1:0] held_read_start,
  output logic [READ_POS_BITS-1:0] held_read_stop,
  output logic [READ_POS_BITS-1:0] held_read_length,
  output logic [CTG_POS_BITS-1:0]  held_contig_start,
  output logic [CTG_POS_BITS-1:0]  held_contig_stop,
  output logic [CTG_POS_BITS-1:0]  held_contig_length,
  output logic [CID_BITS-1:0]      held_contig_id,
  output logic                     held_reverse,
  output logic [SCORE_BITS-1:0]    held_score
);

  // The held record reads as zero after reset until a first record is stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_read_start    <= '0;
      held_read_stop     <= '0;
      held_read_length   <= '0;
      held_contig_start  <= '0;
      held_contig_stop   <= '0;
      held_contig_length <= '0;
      held_contig_id     <= '0;
      held_reverse       <= 1'b0;
      held_score         <= '0;
    end else if (load) begin
      held_read_start    <= read_start;
      held_read_stop     <= read_stop;
      held_read_length   <= read_length;
      held_contig_start  <= contig_start;
      held_contig_stop   <= contig_stop;
      held_contig_length <= contig_length;
      held_contig_id     <= contig_id;
      held_reverse       <= reverse_strand;
      held_score         <= align_score;
    end
  end

endmodule

[design/sec_classify.sv]
// ----------------------------------------------------------------------------
// sec_classify
// Projects both contig spans onto the read and classifies the pair.
// ----------------------------------------------------------------------------
module sec_classify
  import sec_pkg::*;
#(
  parameter int READ_POS_BITS = READ_POS_BITS_DEF,
  parameter int CTG_POS_BITS  = CTG_POS_BITS_DEF,
  parameter int CID_BITS      = CID_BITS_DEF
) (
  // Current record (aln1)
  input  logic [READ_POS_BITS-1:0]  a_read_start,
  input  logic [READ_POS_BITS-1:0]  a_read_stop,
  input  logic [READ_POS_BITS-1:0]  a_read_length,
  input  logic [CTG_POS_BITS-1:0]   a_contig_start,
  input  logic [CTG_POS_BITS-1:0]   a_contig_stop,
  input  logic [CTG_POS_BITS-1:0]   a_contig_length,
  input  logic [CID_BITS-1:0]       a_contig_id,
  input  logic                      a_reverse,
  input  logic [SCORE_BITS-1:0]     a_score,
  // Held record (aln2)
  input  logic [READ_POS_BITS-1:0]  b_read_start,
  input  logic [READ_POS_BITS-1:0]  b_read_stop,
  input  logic [CTG_POS_BITS-1:0]   b_contig_start,
  input  logic [CTG_POS_BITS-1:0]   b_contig_stop,
  input  logic [CTG_POS_BITS-1:0]   b_contig_length,
  input  logic [CID_BITS-1:0]       b_contig_id,
  input  logic                      b_reverse,
  input  logic [SCORE_BITS-1:0]     b_score,
  // Result
  output sec_status_t               status,
  output logic [CID_BITS-1:0]       cid_high,
  output logic [CID_BITS-1:0]       cid_low,
  output logic                      end_high,
  output logic                      end_low,
  output logic [GAP_BITS-1:0]       gap,
  output logic [OVL_BITS-1:0]       overlap_len,
  output logic [SCORE_BITS-1:0]     edge_score,
  output logic [GAP_POS_BITS-1:0]   gap_pos,
  output logic                      gap_read_reverse,
  output logic                      gap_read_present
);

  // Working width: the widest position plus room for sums and negation.
  localparam int PW = (READ_POS_BITS > CTG_POS_BITS) ? READ_POS_BITS : CTG_POS_BITS;
  localparam int W  = PW + 4;
  localparam int XW = 64;

  logic signed [W-1:0] ars, are, arl, acs, ace, acl;
  logic signed [W-1:0] brs, bre, bcs, bce, bcl;
  logic signed [W-1:0] s1, e1, s2, e2;
  logic signed [W-1:0] gap_w, gstart_w, len_a, len_b, minlen, neg_gap;
  logic signed [XW-1:0] gap_x, gstart_x, minlen_x;
  logic                contain, circular, end1, end2;
  sec_status_t         st;

  // Zero-extend the unsigned coordinates into the signed working width.
  assign ars = $signed({{(W-READ_POS_BITS){1'b0}}, a_read_start});
  assign are = $signed({{(W-READ_POS_BITS){1'b0}}, a_read_stop});
  assign arl = $signed({{(W-READ_POS_BITS){1'b0}}, a_read_length});
  assign acs = $signed({{(W-CTG_POS_BITS){1'b0}}, a_contig_start});
  assign ace = $signed({{(W-CTG_POS_BITS){1'b0}}, a_contig_stop});
  assign acl = $signed({{(W-CTG_POS_BITS){1'b0}}, a_contig_length});
  assign brs = $signed({{(W-READ_POS_BITS){1'b0}}, b_read_start});
  assign bre = $signed({{(W-READ_POS_BITS){1'b0}}, b_read_stop});
  assign bcs = $signed({{(W-CTG_POS_BITS){1'b0}}, b_contig_start});
  assign bce = $signed({{(W-CTG_POS_BITS){1'b0}}, b_contig_stop});
  assign bcl = $signed({{(W-CTG_POS_BITS){1'b0}}, b_contig_length});

  // Contig spans projected into read coordinates.
  assign s1 = ars - acs;
  assign e1 = are + (acl - ace);
  assign s2 = brs - bcs;
  assign e2 = bre + (bcl - bce);

  assign contain  = (s1 >= s2 && e1 <= e2) || (s2 >= s1 && e2 <= e1);
  assign circular = (a_contig_id == b_contig_id);

  // The record that starts first on the read faces the other one with its tail.
  always_comb begin
    if (s1 <= s2) begin
      end1     = a_reverse ? END_5P : END_3P;
      end2     = b_reverse ? END_3P : END_5P;
      gap_w    = s2 - e1;
      gstart_w = e1;
    end else begin
      end1     = a_reverse ? END_3P : END_5P;
      end2     = b_reverse ? END_5P : END_3P;
      gap_w    = s1 - e2;
      gstart_w = e2;
    end
  end

  assign len_a   = are - ars;
  assign len_b   = bre - brs;
  assign minlen  = (len_a < len_b) ? len_a : len_b;
  assign neg_gap = -gap_w;

  // Rejection order: containment, circular, short, gap error, bad overlap.
  always_comb begin
    if (contain) begin
      st = ST_CONTAIN;
    end else if (circular) begin
      st = ST_CIRCULAR;
    end else if (gap_w < -minlen) begin
      st = ST_SHORT;
    end else if (gap_w < -arl) begin
      st = ST_GAPERR;
    end else if (gap_w < 0 && (acl < neg_gap || bcl < neg_gap)) begin
      st = ST_BADOVL;
    end else begin
      st = ST_EDGE;
    end
  end

  assign gap_x    = XW'(gap_w);
  assign gstart_x = XW'(gstart_w);
  assign minlen_x = XW'(minlen);

  // Result fields; a rejected pair carries only its status.
  always_comb begin
    status           = st;
    cid_high         = '0;
    cid_low          = '0;
    end_high         = 1'b0;
    end_low          = 1'b0;
    gap              = '0;
    overlap_len      = '0;
    edge_score       = '0;
    gap_pos          = '0;
    gap_read_reverse = 1'b0;
    gap_read_present = 1'b0;
    if (st == ST_EDGE) begin
      if (a_contig_id < b_contig_id) begin
        cid_high         = b_contig_id;
        cid_low          = a_contig_id;
        end_high         = end2;
        end_low          = end1;
        gap_read_reverse = b_reverse;
      end else begin
        cid_high         = a_contig_id;
        cid_low          = b_contig_id;
        end_high         = end1;
        end_low          = end2;
        gap_read_reverse = a_reverse;
      end
      gap         = gap_x[GAP_BITS-1:0];
      overlap_len = (minlen < 0) ? '0 : minlen_x[OVL_BITS-1:0];
      edge_score  = (a_score < b_score) ? a_score : b_score;
      if (gap_w > 0) begin
        gap_pos          = (gstart_w < 0) ? '0 : gstart_x[GAP_POS_BITS-1:0];
        gap_read_present = 1'b1;
      end
    end
  end

endmodule
